>>> src/assert_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/crcpf_pkg.sv
// Types, constants and the CRC byte update for the CRC-16 packet framer.
`default_nettype none

package crcpf_pkg;

    localparam int unsigned IDX_W   = 4;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] MAGIC_FIRST  = 8'hA5;
    localparam logic [7:0] MAGIC_SECOND = 8'h5A;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_PACKET  = 2'd1;
    localparam logic [1:0] STAT_START_OPEN = 2'd2;

    localparam logic REG_VERSION = 1'b0;

    // header byte positions
    localparam logic [IDX_W-1:0] HDR_MAGIC0  = 4'd0;
    localparam logic [IDX_W-1:0] HDR_MAGIC1  = 4'd1;
    localparam logic [IDX_W-1:0] HDR_VERSION = 4'd2;
    localparam logic [IDX_W-1:0] HDR_TYPE    = 4'd3;
    localparam logic [IDX_W-1:0] HDR_CNT0    = 4'd4;
    localparam logic [IDX_W-1:0] HDR_CNT1    = 4'd5;
    localparam logic [IDX_W-1:0] HDR_SEQ0    = 4'd6;
    localparam logic [IDX_W-1:0] HDR_SEQ1    = 4'd7;
    localparam logic [IDX_W-1:0] HDR_SEQ2    = 4'd8;
    localparam logic [IDX_W-1:0] HDR_SEQ3    = 4'd9;
    localparam logic [IDX_W-1:0] HDR_CRC_LO  = 4'd10;

    // payload item positions
    localparam logic [IDX_W-1:0] PLD_DATA   = 4'd0;
    localparam logic [IDX_W-1:0] PLD_CRC_LO = 4'd1;

    typedef struct packed {
        logic        action;
        logic [7:0]  packet_type;
        logic [31:0] sequence_number;
        logic [15:0] payload_count;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_in_run;
        logic       packet_end;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic push;
    } t_emit_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            v = v[15] ? ({v[14:0], 1'b0} ^ CRC_POLY) : {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/crcpf_cfg.sv
// APB register block holding the protocol version byte.
`default_nettype none

module crcpf_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crcpf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [crcpf_pkg::PDATA_W-1:0] pwdata,
    output logic      [crcpf_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output logic      [7:0]                    o_version
);

    logic       w_version_sel;
    logic [7:0] r_version;

    assign w_version_sel = (paddr[crcpf_pkg::PADDR_W-1] == crcpf_pkg::REG_VERSION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= 8'd1;
        end else if (psel && penable && pwrite && pready && w_version_sel) begin
            r_version <= pwdata[7:0];
        end
    end

    assign pready    = 1'b1;
    assign prdata    = w_version_sel ? {{(crcpf_pkg::PDATA_W-8){1'b0}}, r_version} : '0;
    assign o_version = r_version;

endmodule

`default_nettype wire

>>> src/crcpf_emit.sv
// Item register, byte sequencer, packet state and running CRC.
`default_nettype none

module crcpf_emit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire crcpf_pkg::t_in_item   i_in_item,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_version,
    input  wire logic                  i_can_push,
    output crcpf_pkg::t_emit_stat      o_stat,
    output crcpf_pkg::t_out_item       o_item
);

    crcpf_pkg::t_in_item            r_item;
    logic                           r_busy;
    logic [crcpf_pkg::IDX_W-1:0]    r_idx;
    logic [15:0]                    r_crc;
    logic [15:0]                    r_left;
    logic                           r_open;
    logic [15:0]                    n_crc;
    logic [15:0]                    n_left;
    logic                           n_open;

    logic       w_fire;
    logic       w_in_acc;
    logic [7:0] w_byte;
    logic [1:0] w_status;
    logic       w_last;
    logic       w_end;
    logic       w_cov;
    logic       w_close;
    logic       w_open_set;

    always_comb begin
        w_byte     = '0;
        w_status   = crcpf_pkg::STAT_OK;
        w_last     = 1'b0;
        w_end      = 1'b0;
        w_cov      = 1'b0;
        w_close    = 1'b0;
        w_open_set = 1'b0;
        n_crc      = r_crc;
        n_left     = r_left;
        n_open     = r_open;
        if (r_item.action == crcpf_pkg::ACT_START) begin
            if (r_open) begin
                w_status = crcpf_pkg::STAT_START_OPEN;
                w_last   = 1'b1;
            end else begin
                case (r_idx)
                    crcpf_pkg::HDR_MAGIC0:  w_byte = crcpf_pkg::MAGIC_FIRST;
                    crcpf_pkg::HDR_MAGIC1:  w_byte = crcpf_pkg::MAGIC_SECOND;
                    crcpf_pkg::HDR_VERSION: begin
                        w_byte = i_version;
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_TYPE: begin
                        w_byte = r_item.packet_type;
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_CNT0: begin
                        w_byte = r_item.payload_count[7:0];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_CNT1: begin
                        w_byte = r_item.payload_count[15:8];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_SEQ0: begin
                        w_byte = r_item.sequence_number[7:0];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_SEQ1: begin
                        w_byte = r_item.sequence_number[15:8];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_SEQ2: begin
                        w_byte = r_item.sequence_number[23:16];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_SEQ3: begin
                        w_byte = r_item.sequence_number[31:24];
                        w_cov  = 1'b1;
                    end
                    crcpf_pkg::HDR_CRC_LO:  w_byte = r_crc[7:0];
                    default: begin
                        w_byte  = r_crc[15:8];
                        w_end   = 1'b1;
                        w_last  = 1'b1;
                        w_close = 1'b1;
                    end
                endcase
                if (r_idx == crcpf_pkg::HDR_SEQ3 && r_item.payload_count != 16'd0) begin
                    w_last     = 1'b1;
                    w_open_set = 1'b1;
                end
            end
        end else begin
            if (!r_open) begin
                w_status = crcpf_pkg::STAT_NO_PACKET;
                w_last   = 1'b1;
            end else begin
                case (r_idx)
                    crcpf_pkg::PLD_DATA: begin
                        w_byte = r_item.payload_byte;
                        w_cov  = 1'b1;
                        n_left = r_left - 16'd1;
                        w_last = (r_left != 16'd1);
                    end
                    crcpf_pkg::PLD_CRC_LO: w_byte = r_crc[7:0];
                    default: begin
                        w_byte  = r_crc[15:8];
                        w_end   = 1'b1;
                        w_last  = 1'b1;
                        w_close = 1'b1;
                    end
                endcase
            end
        end
        if (w_cov) begin
            n_crc = crcpf_pkg::crc_byte(r_crc, w_byte);
        end
        if (w_open_set) begin
            n_open = 1'b1;
            n_left = r_item.payload_count;
        end
        if (w_close) begin
            n_crc  = crcpf_pkg::CRC_INIT;
            n_open = 1'b0;
            n_left = '0;
        end
    end

    assign w_fire     = r_busy && i_can_push;
    assign o_in_stall = r_busy && !(w_fire && w_last);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_crc  <= crcpf_pkg::CRC_INIT;
            r_left <= '0;
            r_open <= 1'b0;
        end else begin
            if (w_fire) begin
                r_crc  <= n_crc;
                r_left <= n_left;
                r_open <= n_open;
                r_idx  <= w_last ? '0 : r_idx + crcpf_pkg::IDX_W'(1);
            end
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_fire && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_item;
        end
    end

    assign o_stat.busy        = r_busy;
    assign o_stat.push        = w_fire;
    assign o_item.out_byte    = w_byte;
    assign o_item.status      = w_status;
    assign o_item.last_in_run = w_last;
    assign o_item.packet_end  = w_end;

endmodule

`default_nettype wire

>>> src/crcpf_outreg.sv
// Output register that holds one result item toward the stream side.
`default_nettype none

module crcpf_outreg (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire crcpf_pkg::t_out_item  i_item,
    output logic                       o_can_push,
    output logic                       o_valid,
    output crcpf_pkg::t_out_item       o_item,
    input  wire logic                  i_stall
);

    logic                 r_valid;
    crcpf_pkg::t_out_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_item <= i_item;
        end
    end

    assign o_can_push = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

endmodule

`default_nettype wire

>>> src/crc16_packet_framer_core.sv
// Top level of the CRC-16 packet framer: config port, sequencer and output register.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------
//  input    | in        | i_in_valid/o_in_stall  | i_in_item  (t_in_item)
//  output   | out       | o_out_valid/i_out_stall| o_out_item (t_out_item)
//  config   | in        | psel/penable/pready    | paddr, pwdata, prdata
//
// The byte sequencer feeding the output register gives one result byte per cycle
// unless the output stalls; the next item is taken in the cycle the current item's
// last byte enters the output register. Payload items emit their byte, plus the CRC bytes
// when closing the packet; start items emit the header, plus the CRC when the payload
// count is zero; errors emit one zero byte. Results pass the item and output registers.
// Reset is synchronous; no packet open and the CRC at its initial value after reset.
// A stall on the output holds the output register and, once full, the sequencer.
`default_nettype none
`include "assert_macros.svh"

module crc16_packet_framer_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire crcpf_pkg::t_in_item           i_in_item,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output crcpf_pkg::t_out_item               o_out_item,
    input  wire logic                          i_out_stall,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [crcpf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [crcpf_pkg::PDATA_W-1:0] pwdata,
    output logic      [crcpf_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    logic [7:0]            w_version_byte;
    logic                  w_can_push;
    logic                  w_in_acc;
    logic                  w_out_end;
    logic                  w_out_err;
    logic                  w_err_clean;
    crcpf_pkg::t_emit_stat w_stat;
    crcpf_pkg::t_out_item  w_item;

    crcpf_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_version (w_version_byte)
    );

    crcpf_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_version  (w_version_byte),
        .i_can_push (w_can_push),
        .o_stat     (w_stat),
        .o_item     (w_item)
    );

    crcpf_outreg u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_stat.push),
        .i_item     (w_item),
        .o_can_push (w_can_push),
        .o_valid    (o_out_valid),
        .o_item     (o_out_item),
        .i_stall    (i_out_stall)
    );

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_end   = o_out_valid && o_out_item.packet_end;
    assign w_out_err   = o_out_valid && (o_out_item.status != crcpf_pkg::STAT_OK);
    assign w_err_clean = (o_out_item.out_byte == 8'd0) && o_out_item.last_in_run
                         && !o_out_item.packet_end;

    `ASSERT_SAME(a_end_is_last, i_clk, i_rst_n, w_out_end, o_out_item.last_in_run)
    `ASSERT_SAME(a_error_zero, i_clk, i_rst_n, w_out_err, w_err_clean)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_in_acc, w_stat.busy)
    `ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_stat.push, o_out_valid)
    `ASSERT_SAME(a_stall_when_blocked, i_clk, i_rst_n, w_stat.busy && !w_can_push, o_in_stall)

endmodule

`default_nettype wire
